### rtl/core/bsvr_pkg.sv
// Package for the bitstream field and VBR reader.
// Holds command codes, queue entry type, kind and state enums and size constants.
// No dependencies.
package bsvr_pkg;

  localparam int BufferBytesDef = 4096;
  localparam int QueueDepth     = 2;

  localparam logic [2:0] CMD_LOAD   = 3'd0;
  localparam logic [2:0] CMD_SETPOS = 3'd1;
  localparam logic [2:0] CMD_FIXED  = 3'd2;
  localparam logic [2:0] CMD_VBR32  = 3'd3;
  localparam logic [2:0] CMD_VBR64  = 3'd4;

  typedef enum logic [2:0] {
    K_LOAD,
    K_SETPOS,
    K_FIXED,
    K_VBR32,
    K_VBR64,
    K_BAD
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [11:0] addr;
    logic [7:0]  data;
    logic [15:0] pos;
    logic [6:0]  width;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_CHECK,
    B_FETCH,
    B_MERGE,
    B_DONE
  } back_state_e;

endpackage

### rtl/core/bsvr_front.sv
// Front end: accepts input transactions, classifies them and queues them; unknown command codes are dropped.
// Depends on bsvr_pkg.
module bsvr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [47:0]          s_axis_tdata,
  output logic                 q_valid_o,
  output bsvr_pkg::entry_t     q_entry_o,
  input  logic                 q_pop_i
);

  bsvr_pkg::entry_t fifo_q [bsvr_pkg::QueueDepth];
  logic       wp_q, wp_d, rp_q, rp_d;
  logic [1:0] cnt_q, cnt_d;

  logic [2:0]       cmd;
  logic [6:0]       w;
  logic             keep;
  logic             push;
  logic             pop;
  bsvr_pkg::entry_t ent;

  assign cmd = s_axis_tdata[2:0];
  assign w   = s_axis_tdata[45:39];

  always_comb begin
    ent       = '0;
    ent.addr  = s_axis_tdata[14:3];
    ent.data  = s_axis_tdata[22:15];
    ent.pos   = s_axis_tdata[38:23];
    ent.width = w;
    keep      = 1'b1;
    unique case (cmd)
      bsvr_pkg::CMD_LOAD:   ent.kind = bsvr_pkg::K_LOAD;
      bsvr_pkg::CMD_SETPOS: ent.kind = bsvr_pkg::K_SETPOS;
      bsvr_pkg::CMD_FIXED:
        ent.kind = (w == 7'd0 || w > 7'd64) ? bsvr_pkg::K_BAD : bsvr_pkg::K_FIXED;
      bsvr_pkg::CMD_VBR32:
        ent.kind = (w < 7'd2 || w > 7'd32) ? bsvr_pkg::K_BAD : bsvr_pkg::K_VBR32;
      bsvr_pkg::CMD_VBR64:
        ent.kind = (w < 7'd2 || w > 7'd32) ? bsvr_pkg::K_BAD : bsvr_pkg::K_VBR64;
      default: begin
        ent.kind = bsvr_pkg::K_BAD;
        keep     = 1'b0;
      end
    endcase
  end

  assign s_axis_tready = (cnt_q != 2'(bsvr_pkg::QueueDepth));
  assign push          = s_axis_tvalid && s_axis_tready && keep;
  assign pop           = q_pop_i && (cnt_q != 2'd0);
  assign q_valid_o     = (cnt_q != 2'd0);
  assign q_entry_o     = fifo_q[rp_q];

  always_comb begin
    wp_d  = push ? ~wp_q : wp_q;
    rp_d  = pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wp_q] <= ent;
    end
  end

endmodule

### rtl/core/bsvr_back.sv
// Back end: byte buffer, bit cursor and the read sequencer with output register.
// Depends on bsvr_pkg.
module bsvr_back #(
  parameter int BUFFER_BYTES = bsvr_pkg::BufferBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [12:0]       cfg_wdata_i,
  input  logic              q_valid_i,
  input  bsvr_pkg::entry_t  q_entry_i,
  output logic              q_pop_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [87:0]       m_axis_tdata
);

  localparam int AW  = $clog2(BUFFER_BYTES);
  localparam int VBW = $clog2(BUFFER_BYTES * 8 + 1);
  localparam int CW  = (VBW > 17) ? VBW : 17;

  logic [7:0] mem [BUFFER_BYTES];

  bsvr_pkg::back_state_e state_q, state_d;
  bsvr_pkg::kind_e       kind_q, kind_d;

  logic [12:0] len_q;
  logic [15:0] cursor_q, cursor_d;
  logic [6:0]  n_q, n_d;
  logic [5:0]  tn_q, tn_d;
  logic        hi_q, hi_d;
  logic        part_q, part_d;
  logic [6:0]  shift_q, shift_d;
  logic [63:0] val_q, val_d;
  logic        err_q, err_d;
  logic [39:0] acc_q, acc_d;
  logic [2:0]  idx_q, idx_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [7:0]  rdata_q;
  logic        ovalid_q, ovalid_d;
  logic [87:0] odata_q, odata_d;

  logic [CW-1:0] lim, end_pos;
  logic          past;
  logic [5:0]    cnt_calc;
  logic [AW-1:0] raddr;
  logic          we;
  logic [39:0]   sh_acc;
  logic [31:0]   tmask, chunk, dchunk;
  logic          more;
  logic [63:0]   vshift;
  logic [6:0]    shift_n, limit;
  logic          out_free;
  logic [63:0]   res_val;

  assign lim = ((32'(len_q) > BUFFER_BYTES) ? CW'(BUFFER_BYTES) : CW'(len_q)) << 3;
  assign end_pos  = CW'(cursor_q) + CW'(tn_q);
  assign past     = end_pos > lim;
  assign cnt_calc = (6'(cursor_q[2:0]) + tn_q + 6'd7) >> 3;
  assign raddr    = AW'(14'(cursor_q[15:3]) + 14'(idx_q));
  assign sh_acc   = acc_q >> cursor_q[2:0];
  assign tmask    = 32'hFFFF_FFFF >> (6'd32 - tn_q);
  assign chunk    = sh_acc[31:0] & tmask;
  assign dchunk   = chunk & (tmask >> 1);
  assign more     = chunk[5'(tn_q - 6'd1)];
  assign vshift   = 64'(dchunk) << shift_q[5:0];
  assign shift_n  = shift_q + 7'(tn_q) - 7'd1;
  assign limit    = (kind_q == bsvr_pkg::K_VBR64) ? 7'd64 : 7'd32;
  assign out_free = !ovalid_q || m_axis_tready;
  assign res_val  = err_q ? 64'd0 :
                    (kind_q == bsvr_pkg::K_VBR32) ? {32'd0, val_q[31:0]} : val_q;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsvr_pkg::B_IDLE: begin
        if (q_valid_i) begin
          unique case (q_entry_i.kind)
            bsvr_pkg::K_LOAD, bsvr_pkg::K_SETPOS: state_d = bsvr_pkg::B_IDLE;
            bsvr_pkg::K_BAD:                      state_d = bsvr_pkg::B_DONE;
            default:                              state_d = bsvr_pkg::B_CHECK;
          endcase
        end
      end
      bsvr_pkg::B_CHECK: state_d = past ? bsvr_pkg::B_DONE : bsvr_pkg::B_FETCH;
      bsvr_pkg::B_FETCH: if (idx_q == cnt_q) state_d = bsvr_pkg::B_MERGE;
      bsvr_pkg::B_MERGE: begin
        if (kind_q == bsvr_pkg::K_FIXED) begin
          state_d = hi_q ? bsvr_pkg::B_CHECK : bsvr_pkg::B_DONE;
        end else if (!more || shift_n >= limit) begin
          state_d = bsvr_pkg::B_DONE;
        end else begin
          state_d = bsvr_pkg::B_CHECK;
        end
      end
      bsvr_pkg::B_DONE: if (out_free) state_d = bsvr_pkg::B_IDLE;
      default: state_d = bsvr_pkg::B_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    kind_d   = kind_q;
    cursor_d = cursor_q;
    n_d      = n_q;
    tn_d     = tn_q;
    hi_d     = hi_q;
    part_d   = part_q;
    shift_d  = shift_q;
    val_d    = val_q;
    err_d    = err_q;
    acc_d    = acc_q;
    idx_d    = idx_q;
    cnt_d    = cnt_q;
    q_pop_o  = 1'b0;
    we       = 1'b0;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    unique case (state_q)
      bsvr_pkg::B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          kind_d  = q_entry_i.kind;
          n_d     = q_entry_i.width;
          val_d   = 64'd0;
          err_d   = 1'b0;
          shift_d = 7'd0;
          part_d  = 1'b0;
          hi_d    = (q_entry_i.width > 7'd32);
          tn_d    = (q_entry_i.width > 7'd32) ? 6'd32 : q_entry_i.width[5:0];
          unique case (q_entry_i.kind)
            bsvr_pkg::K_LOAD:   we = (32'(q_entry_i.addr) < BUFFER_BYTES);
            bsvr_pkg::K_SETPOS: cursor_d = q_entry_i.pos;
            bsvr_pkg::K_BAD:    err_d = 1'b1;
            default: ;
          endcase
        end
      end
      bsvr_pkg::B_CHECK: begin
        if (past) begin
          err_d = 1'b1;
        end
        idx_d = 3'd0;
        cnt_d = cnt_calc[2:0];
        acc_d = 40'd0;
      end
      bsvr_pkg::B_FETCH: begin
        if (idx_q != 3'd0) begin
          acc_d[{idx_q - 3'd1, 3'b000} +: 8] = rdata_q;
        end
        idx_d = idx_q + 3'd1;
      end
      bsvr_pkg::B_MERGE: begin
        cursor_d = cursor_q + 16'(tn_q);
        if (kind_q == bsvr_pkg::K_FIXED) begin
          if (part_q) begin
            val_d[63:32] = chunk;
          end else begin
            val_d[31:0] = chunk;
          end
          if (hi_q) begin
            hi_d   = 1'b0;
            part_d = 1'b1;
            tn_d   = 6'(n_q - 7'd32);
          end
        end else begin
          val_d = val_q | vshift;
          if (more) begin
            shift_d = shift_n;
            if (shift_n >= limit) begin
              err_d = 1'b1;
            end
          end
        end
      end
      bsvr_pkg::B_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = {7'd0, cursor_q, err_q, res_val};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= bsvr_pkg::B_IDLE;
      len_q    <= 13'd0;
      cursor_q <= 16'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    n_q     <= n_d;
    tn_q    <= tn_d;
    hi_q    <= hi_d;
    part_q  <= part_d;
    shift_q <= shift_d;
    val_q   <= val_d;
    err_q   <= err_d;
    acc_q   <= acc_d;
    idx_q   <= idx_d;
    cnt_q   <= cnt_d;
    odata_q <= odata_d;
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[AW'(q_entry_i.addr)] <= q_entry_i.data;
    end
    rdata_q <= mem[raddr];
  end

endmodule

### rtl/core/bitstream_field_and_vbr_reader_top.sv
// Top level of the bitstream field and VBR reader.
// Depends on bsvr_pkg, bsvr_front and bsvr_back.
//
// Commands enter through a two-entry queue and run one at a time on a byte buffer.
// Load byte and set cursor are done as the command is taken from the queue. A read
// of up to 32 bits runs the check, fetch, merge and done states up to the output
// register; the fetch state reads each buffer byte that the field spans, and the
// buffer read is registered. A fixed read above 32 bits adds a second such part,
// each further VBR chunk repeats from the check, and errors before a fetch skip to done.
// The stream length register resets to zero, so nothing is readable until it is set.
module bitstream_field_and_vbr_reader_top #(
  parameter int BUFFER_BYTES = bsvr_pkg::BufferBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,   // stream_length_bytes
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // command[2:0], byte_address[14:3], byte_value[22:15], new_position[38:23], width[45:39]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // value[63:0], error[64], position_after[80:65]
  output logic [87:0] m_axis_tdata
);

  logic             q_valid;
  logic             q_pop;
  bsvr_pkg::entry_t q_entry;

  bsvr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_valid_o     (q_valid),
    .q_entry_o     (q_entry),
    .q_pop_i       (q_pop)
  );

  bsvr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .q_valid_i     (q_valid),
    .q_entry_i     (q_entry),
    .q_pop_o       (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

### dv/bsvr_checker.sv
// Checker for the bitstream field and VBR reader: watches the command and result
// streams, predicts each result and compares it. Depends on bsvr_pkg.
module bsvr_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [87:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          result_count_o
);
  import bsvr_pkg::*;

  typedef struct {
    logic [63:0] value;
    logic        error;
    logic [15:0] pos;
  } read_result_t;

  logic [7:0]   mem_model [BufferBytesDef];
  logic [15:0]  cursor_model;
  logic [12:0]  length_model;
  read_result_t expected_reads [$];

  assign pending_o = expected_reads.size();

  function automatic int valid_bits();
    int len;
    len = (length_model > BufferBytesDef) ? BufferBytesDef : length_model;
    return len * 8;
  endfunction

  function automatic logic [31:0] take_bits(input int n, inout logic bad);
    int p;
    logic [63:0] acc;
    p = cursor_model;
    acc = '0;
    if (n == 0 || n > 32 || p + n > valid_bits()) begin
      bad = 1'b1;
      return '0;
    end
    for (int i = 0; i < 5; i++) begin
      if (i*8 < (p % 8) + n && (p/8 + i) < BufferBytesDef) begin
        acc |= 64'(mem_model[p/8 + i]) << (8*i);
      end
    end
    acc >>= (p % 8);
    cursor_model = 16'(p + n);
    return 32'(acc & ((64'd1 << n) - 1));
  endfunction

  function automatic logic [63:0] fixed_read(input int n, inout logic bad);
    logic [63:0] lo, hi;
    if (n == 0 || n > 64) begin
      bad = 1'b1;
      return '0;
    end
    if (n <= 32) return 64'(take_bits(n, bad));
    lo = 64'(take_bits(32, bad));
    if (bad) return '0;
    hi = 64'(take_bits(n - 32, bad));
    if (bad) return '0;
    return lo | (hi << 32);
  endfunction

  function automatic logic [63:0] vbr_read(input int n, input bit wide, inout logic bad);
    logic [63:0] acc;
    logic [31:0] chunk, more;
    int shift;
    acc = '0;
    shift = 0;
    if (n < 2 || n > 32) begin
      bad = 1'b1;
      return '0;
    end
    more = 32'd1 << (n - 1);
    forever begin
      chunk = take_bits(n, bad);
      if (bad) return '0;
      if (shift < 64) acc |= 64'(chunk & (more - 1)) << shift;
      if ((chunk & more) == 0) break;
      shift += n - 1;
      if (shift >= (wide ? 64 : 32)) begin
        bad = 1'b1;
        return '0;
      end
    end
    if (!wide) acc &= 64'hFFFF_FFFF;
    return acc;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [2:0]   cmd;
    logic         bad;
    logic [63:0]  v;
    read_result_t r;
    if (!rst_ni) begin
      cursor_model = '0;
      length_model = '0;
      fail_count_o = 0;
      result_count_o = 0;
      expected_reads.delete();
    end else begin
      if (cfg_we_i) length_model = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        cmd = s_axis_tdata[2:0];
        bad = 1'b0;
        v = '0;
        case (cmd)
          CMD_LOAD:   mem_model[s_axis_tdata[14:3]] = s_axis_tdata[22:15];
          CMD_SETPOS: cursor_model = s_axis_tdata[38:23];
          CMD_FIXED:  v = fixed_read(int'(s_axis_tdata[45:39]), bad);
          CMD_VBR32:  v = vbr_read(int'(s_axis_tdata[45:39]), 1'b0, bad);
          CMD_VBR64:  v = vbr_read(int'(s_axis_tdata[45:39]), 1'b1, bad);
          default: ;
        endcase
        if (cmd inside {CMD_FIXED, CMD_VBR32, CMD_VBR64}) begin
          r.value = bad ? '0 : v;
          r.error = bad;
          r.pos = cursor_model;
          expected_reads.push_back(r);
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        result_count_o++;
        if (expected_reads.size() == 0) begin
          report("unexpected result", m_axis_tdata[63:0], '0);
        end else begin
          r = expected_reads.pop_front();
          if (m_axis_tdata[63:0] !== r.value) report("value", m_axis_tdata[63:0], r.value);
          if (m_axis_tdata[64] !== r.error) report("error", 64'(m_axis_tdata[64]), 64'(r.error));
          if (m_axis_tdata[80:65] !== r.pos) report("position", 64'(m_axis_tdata[80:65]), 64'(r.pos));
        end
      end
    end
  end
endmodule

### dv/tb.sv
// Testbench top for the bitstream field and VBR reader: drives commands and the
// stream length register, stalls both sides, gives the verdict.
// Depends on bsvr_pkg, bsvr_checker and the reader top.
module tb;
  import bsvr_pkg::*;

  localparam int IdleLimit = 20000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [12:0] cfg_wdata_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready;
  logic [87:0] m_axis_tdata;
  int          fail_count, pending, result_count;
  int          idle_cycles;
  bit          quiet_phase;

  bitstream_field_and_vbr_reader_top DUT (.*);

  bsvr_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls in bursts
  initial begin
    int n;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        n = $urandom_range(1, 17);
        repeat (n - 1) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout with %0d results pending", pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // outside the quiet phase, random gaps drop tvalid between transactions; drain() drops it
  task automatic send(input logic [2:0] cmd, input logic [11:0] addr, input logic [7:0] data,
                      input logic [15:0] pos, input logic [6:0] width);
    if (!quiet_phase && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b0, width, pos, data, addr, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic set_length(input logic [12:0] len);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic fill(input int lo, input int hi);
    for (int a = lo; a < hi; a++) send(CMD_LOAD, 12'(a), 8'($urandom), 16'($urandom), 7'($urandom));
  endtask

  // random reads: cursor sets range up to span_bits, which lies past the loaded prefix
  task automatic random_read(input int span_bits);
    logic [2:0] cmd;
    logic [6:0] w;
    int r;
    r = $urandom_range(0, 9);
    cmd = (r < 3) ? CMD_FIXED : (r < 6) ? CMD_VBR32 : (r < 9) ? CMD_VBR64 : 3'($urandom_range(5, 7));
    w = ($urandom_range(0, 9) == 0) ? 7'($urandom) :
        (cmd == CMD_FIXED) ? 7'($urandom_range(1, 64)) : 7'($urandom_range(2, 12));
    if ($urandom_range(0, 3) == 0) send(CMD_SETPOS, 12'($urandom), 8'($urandom),
                                         16'($urandom_range(0, span_bits)), 7'($urandom));
    send(cmd, 12'($urandom), 8'($urandom), 16'($urandom), w);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    quiet_phase   = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // length zero: everything past the end
    send(CMD_FIXED, '0, '0, '0, 7'd1);
    send(CMD_VBR64, '0, '0, '0, 7'd6);
    fill(0, 64);
    set_length(13'd64);
    send(CMD_SETPOS, '0, '0, 16'd0, '0);
    send(CMD_FIXED, '0, '0, '0, 7'd0);
    send(CMD_FIXED, '0, '0, '0, 7'd65);
    send(CMD_FIXED, '0, '0, '0, 7'd127);
    send(CMD_VBR32, '0, '0, '0, 7'd1);
    send(CMD_VBR64, '0, '0, '0, 7'd33);
    send(CMD_FIXED, '0, '0, '0, 7'd64);
    send(CMD_FIXED, '0, '0, '0, 7'd33);
    send(CMD_VBR32, '0, '0, '0, 7'd32);
    send(CMD_VBR64, '0, '0, '0, 7'd2);
    send(3'd7, '0, '0, '0, '0);
    send(CMD_SETPOS, '0, '0, 16'd500, '0);
    send(CMD_FIXED, '0, '0, '0, 7'd48);
    send(CMD_SETPOS, '0, '0, 16'hFFFF, '0);
    send(CMD_FIXED, '0, '0, '0, 7'd8);
    // all-ones data: VBR overflow in both widths
    for (int a = 64; a < 80; a++) send(CMD_LOAD, 12'(a), 8'hFF, '0, '0);
    set_length(13'd80);
    send(CMD_SETPOS, '0, '0, 16'd512, '0);
    send(CMD_VBR32, '0, '0, '0, 7'd4);
    send(CMD_SETPOS, '0, '0, 16'd512, '0);
    send(CMD_VBR64, '0, '0, '0, 7'd32);
    send(CMD_LOAD, 12'hFFF, 8'hA5, '0, '0);

    set_length(13'd8191);   // above buffer size
    send(CMD_SETPOS, '0, '0, 16'd32760, '0);
    send(CMD_FIXED, '0, '0, '0, 7'd8);

    for (int phase = 0; phase < 4; phase++) begin
      int len;
      len = (phase == 0) ? 1 : (phase == 1) ? 8 : (phase == 2) ? 80 : 256;
      if (phase == 3) fill(80, len);
      fill(0, (len < 80) ? len : 80);
      set_length(13'(len));
      if (phase == 3) quiet_phase = 1'b0;
      for (int i = 0; i < 120; i++) begin
        if (phase == 3 && i > 90) quiet_phase = 1'b1;
        random_read(len * 8 + 8);
        if ($urandom_range(0, 7) == 0)
          send(CMD_LOAD, 12'($urandom_range(0, (len < 80) ? len - 1 : 79)), 8'($urandom), '0, '0);
      end
    end

    drain();
    $display("covered loads, cursor sets, fixed and VBR reads at lengths from 0 to past the buffer");
    $display("%0d results checked, %0d mismatches", result_count, fail_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
